FILE: hw/rtl/stn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Spanning tree node package
// Widths, message kinds, node phases, cfg indices and the control and status
// structs that pass between the controller and the serial target scanner.
// ----------------------------------------------------------------------------
package stn_pkg;

    localparam int SET_W     = 64;
    localparam int ID_W      = 6;
    localparam int KIND_W    = 2;
    localparam int PHASE_W   = 2;
    localparam int PARENT_W  = 7;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 144;
    localparam int M_TUSER_W = 3;

    localparam logic [KIND_W-1:0] KIND_NO       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_YES      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUESTION = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID  = 2'd3;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_MESSAGE = 1'b1;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ACTIVE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DONE   = 2'd2;

    localparam logic [PARENT_W-1:0] PARENT_NONE = 7'h7F;
    localparam logic [CNT_W-1:0]    CNT_MAX     = 7'h7F;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_SET = 1'b1;

    typedef struct packed {
        logic load;
        logic take;
    } scan_ctrl_t;

    typedef struct packed {
        logic            hit;
        logic            last;
        logic            empty;
        logic [ID_W-1:0] idx;
    } scan_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/stn_bitcnt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial population count
// Shifts a node set out one bit per cycle and counts the ones; busy stays
// high until no set bit is left.
// ----------------------------------------------------------------------------
module stn_bitcnt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire logic [stn_pkg::SET_W-1:0]     vec,
    output logic                               busy,
    output logic [stn_pkg::CNT_W-1:0]          count
);

    logic [stn_pkg::SET_W-1:0] sr_reg, sr_next;
    logic [stn_pkg::CNT_W-1:0] count_reg, count_next;

    assign busy  = |sr_reg;
    assign count = count_reg;

    always_comb begin
        sr_next    = sr_reg;
        count_next = count_reg;
        if (load) begin
            sr_next    = vec;
            count_next = '0;
        end else if (busy) begin
            sr_next    = sr_reg >> 1;
            count_next = count_reg + stn_pkg::CNT_W'(sr_reg[0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sr_reg    <= '0;
            count_reg <= '0;
        end else begin
            sr_reg    <= sr_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/stn_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial target scanner
// Walks a target set from node 0 upward one bit per cycle. It passes over
// clear bits on its own and holds on a set bit until the controller takes it.
// ----------------------------------------------------------------------------
module stn_scan (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire stn_pkg::scan_ctrl_t           ctrl,
    input  wire logic [stn_pkg::SET_W-1:0]     targets,
    output stn_pkg::scan_stat_t                stat
);

    logic [stn_pkg::SET_W-1:0] sr_reg, sr_next;
    logic [stn_pkg::ID_W-1:0]  idx_reg, idx_next;
    logic                      advance;

    assign advance = (|sr_reg) && (!sr_reg[0] || ctrl.take);

    assign stat.hit   = sr_reg[0];
    assign stat.last  = ~|sr_reg[stn_pkg::SET_W-1:1];
    assign stat.empty = ~|sr_reg;
    assign stat.idx   = idx_reg;

    always_comb begin
        sr_next  = sr_reg;
        idx_next = idx_reg;
        if (ctrl.load) begin
            sr_next  = targets;
            idx_next = '0;
        end else if (advance) begin
            sr_next  = sr_reg >> 1;
            idx_next = idx_reg + stn_pkg::ID_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sr_reg  <= '0;
            idx_reg <= '0;
        end else begin
            sr_reg  <= sr_next;
            idx_reg <= idx_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/spanning_tree_node.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Spanning tree node
// One node of a flooding spanning-tree protocol with bitmap node sets.
//
// The slave channel takes one beat per start command or received message.
// The master channel returns every outgoing message as one beat (a YES or NO
// answer first, then Questions in ascending node order), or one status beat
// when nothing is sent; tlast marks the final beat of an input beat. The user
// must write the neighbor set via the cfg port while idle; nothing checks it.
//
// An input beat first runs a serial count over the neighbor set, bit by bit
// up to its highest set bit, then updates the state. The results follow,
// and the Question scan walks the target set one node per cycle, but waits
// on a target while the master channel is stalled.
// s_tready is high only between items. A stalled master channel holds its
// beat in the output register and the scan waits on it.
// Reset clears the phase to idle, the parent to none, the tree links and the
// neighbor set; no beat is pending afterwards.
// ----------------------------------------------------------------------------
module spanning_tree_node #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata: sender[5:0], visited_in[69:6], zero fill.
    input  wire logic [stn_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: operation[0], msg_kind[2:1].
    input  wire logic [stn_pkg::S_TUSER_W-1:0]     s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // m_tdata: destination[5:0], visited_out[69:6], node_phase[71:70],
    // parent_node[78:72], tree_links[142:79], zero fill.
    output logic [stn_pkg::M_TDATA_W-1:0]          m_tdata,
    // m_tuser: send_valid[0], out_kind[2:1].
    output logic [stn_pkg::M_TUSER_W-1:0]          m_tuser,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_we,
    input  wire logic [stn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [stn_pkg::SET_W-1:0]         cfg_data
);

    localparam int SET_W    = stn_pkg::SET_W;
    localparam int ID_W     = stn_pkg::ID_W;
    localparam int KIND_W   = stn_pkg::KIND_W;
    localparam int PHASE_W  = stn_pkg::PHASE_W;
    localparam int PARENT_W = stn_pkg::PARENT_W;
    localparam int CNT_W    = stn_pkg::CNT_W;

    localparam logic [CNT_W-1:0] NODES_LIM = CNT_W'(MAX_NODES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_COUNT = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_FIRST = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [SET_W-1:0]    nb_reg;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [PARENT_W-1:0] parent_reg, parent_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SET_W-1:0]    tree_reg, tree_next;

    logic                op_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [ID_W-1:0]     snd_reg;
    logic [SET_W-1:0]    z_reg;
    logic [SET_W-1:0]    qvis_reg, qvis_next;
    logic                first_send_reg, first_send_next;
    logic [KIND_W-1:0]   first_kind_reg, first_kind_next;

    logic                        m_tvalid_reg;
    logic [stn_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [stn_pkg::M_TUSER_W-1:0] m_tuser_reg;
    logic                        m_tlast_reg;

    logic [SET_W-1:0]    set_mask;
    logic [SET_W-1:0]    nb_m;
    logic [SET_W-1:0]    sbit;
    logic [SET_W-1:0]    y_set;
    logic [SET_W-1:0]    targets;
    logic [CNT_W-1:0]    count_inc;
    logic [CNT_W-1:0]    pop;
    logic                pop_busy;
    logic                in_fire;
    logic                out_free;
    logic                out_load;
    logic                out_send;
    logic [KIND_W-1:0]   out_kind;
    logic [ID_W-1:0]     out_dest;
    logic [SET_W-1:0]    out_vis;
    logic                out_last;

    stn_pkg::scan_ctrl_t scan_ctrl;
    stn_pkg::scan_stat_t scan_stat;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        for (int i = 0; i < SET_W; i++) begin
            set_mask[i] = (i < MAX_NODES);
        end
    end

    assign nb_m  = nb_reg & set_mask;
    assign sbit  = ({1'b0, snd_reg} < NODES_LIM) ? (SET_W'(1) << snd_reg) : '0;
    assign y_set = nb_m & ~z_reg;
    assign count_inc = (count_reg == stn_pkg::CNT_MAX) ? count_reg
                                                       : count_reg + CNT_W'(1);

    stn_bitcnt u_bitcnt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (in_fire),
        .vec     (nb_m),
        .busy    (pop_busy),
        .count   (pop)
    );

    assign scan_ctrl.load = (state_reg == S_APPLY);
    assign scan_ctrl.take = (state_reg == S_SCAN) && scan_stat.hit && out_free;

    stn_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (scan_ctrl),
        .targets (targets),
        .stat    (scan_stat)
    );

    // Protocol step, evaluated once the neighbor count is known.
    always_comb begin
        phase_next      = phase_reg;
        parent_next     = parent_reg;
        count_next      = count_reg;
        tree_next       = tree_reg;
        targets         = '0;
        qvis_next       = '0;
        first_send_next = 1'b0;
        first_kind_next = stn_pkg::KIND_NO;
        if (op_reg == stn_pkg::OP_START) begin
            if (phase_reg == stn_pkg::PH_IDLE) begin
                targets    = nb_m;
                qvis_next  = nb_m;
                phase_next = (pop == '0) ? stn_pkg::PH_DONE : stn_pkg::PH_ACTIVE;
            end
        end else if (kind_reg != stn_pkg::KIND_INVALID) begin
            unique case (phase_reg)
                stn_pkg::PH_IDLE: begin
                    parent_next     = {1'b0, snd_reg};
                    tree_next       = tree_reg | sbit;
                    first_send_next = 1'b1;
                    first_kind_next = stn_pkg::KIND_YES;
                    count_next      = CNT_W'(1);
                    if (pop == CNT_W'(1)) begin
                        phase_next = stn_pkg::PH_DONE;
                    end else begin
                        targets    = y_set & ~sbit;
                        qvis_next  = (y_set | z_reg | sbit) & set_mask;
                        phase_next = stn_pkg::PH_ACTIVE;
                    end
                end
                stn_pkg::PH_ACTIVE: begin
                    if (kind_reg == stn_pkg::KIND_QUESTION) begin
                        first_send_next = 1'b1;
                        first_kind_next = stn_pkg::KIND_NO;
                    end else begin
                        count_next = count_inc;
                        if (kind_reg == stn_pkg::KIND_YES) begin
                            tree_next = tree_reg | sbit;
                        end
                        if (count_inc == pop) begin
                            phase_next = stn_pkg::PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT: begin
                if (!pop_busy) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                state_next = (first_send_next || (targets == '0)) ? S_FIRST : S_SCAN;
            end
            S_FIRST: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = scan_stat.empty ? S_IDLE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_stat.empty) begin
                    state_next = S_IDLE;
                end else if (scan_ctrl.take) begin
                    out_load = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (state_reg == S_FIRST) begin
            out_send = first_send_reg;
            out_kind = first_kind_reg;
            out_dest = first_send_reg ? snd_reg : '0;
            out_vis  = '0;
            out_last = scan_stat.empty;
        end else begin
            out_send = 1'b1;
            out_kind = stn_pkg::KIND_QUESTION;
            out_dest = scan_stat.idx;
            out_vis  = qvis_reg;
            out_last = scan_stat.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            nb_reg       <= '0;
            phase_reg    <= stn_pkg::PH_IDLE;
            parent_reg   <= stn_pkg::PARENT_NONE;
            count_reg    <= '0;
            tree_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // The node index only names the source of a message, which no
            // output field carries, so a write to it has no effect here.
            if (cfg_we && (cfg_index == stn_pkg::REG_NEIGHBOR_SET)) begin
                nb_reg <= cfg_data;
            end
            if (state_reg == S_APPLY) begin
                phase_reg  <= phase_next;
                parent_reg <= parent_next;
                count_reg  <= count_next;
                tree_reg   <= tree_next;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg   <= s_tuser[0];
            kind_reg <= s_tuser[2:1];
            snd_reg  <= s_tdata[ID_W-1:0];
            z_reg    <= s_tdata[ID_W +: SET_W] & set_mask;
        end
        if (state_reg == S_APPLY) begin
            qvis_reg       <= qvis_next;
            first_send_reg <= first_send_next;
            first_kind_reg <= first_kind_next;
        end
        if (out_load) begin
            m_tuser_reg <= {out_kind, out_send};
            m_tdata_reg <= {1'b0, tree_reg, parent_reg, phase_reg, out_vis, out_dest};
            m_tlast_reg <= out_last;
        end
    end

endmodule
`default_nettype wire
